// File: sv/lgge_pkg.sv
// Shared types and constants for the life grid generation engine.
// Used by lgge_row_rule and life_grid_generation_engine; depends on nothing.

package lgge_pkg;

  localparam int GRID_MAX_DEF = 64;

  // Fixed widths of the item fields and registers.
  localparam int MODE_W      = 2;
  localparam int COORD_W     = 6;
  localparam int SIZE_CFG_W  = 7;
  localparam int GENS_W      = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int COUNT_W     = 4;

  localparam logic [SIZE_CFG_W-1:0] GRID_SIZE_RESET = 7'd64;
  localparam logic [GENS_W-1:0]     MAX_GENS_RESET  = 16'd1;

  // Neighbor counts of the B3/S23 rule.
  localparam logic [COUNT_W-1:0] BIRTH_COUNT = 4'd3;
  localparam logic [COUNT_W-1:0] KEEP_COUNT  = 4'd2;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD = 2'd0,
    MODE_RUN  = 2'd1,
    MODE_READ = 2'd2
  } mode_t;

  typedef enum logic {
    CFG_GRID_SIZE = 1'b0,
    CFG_MAX_GENS  = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_WR,
    ST_READ_CAP,
    ST_GEN_START,
    ST_GEN_MID,
    ST_ROW_RD,
    ST_ROW_CAP,
    ST_ROW_CALC,
    ST_GEN_END,
    ST_RESP
  } state_t;

  // Next value of one cell from its live neighbor count and its present value.
  function automatic logic life_rule(input logic [COUNT_W-1:0] cnt, input logic old);
    life_rule = (cnt == BIRTH_COUNT) || ((cnt == KEEP_COUNT) && old);
  endfunction

endpackage

// File: sv/life_grid_generation_engine.sv
// Top level of the life grid generation engine: sequencer, bank routing and result register.
// Depends on lgge_pkg, lgge_bank and lgge_row_rule.
//
//  channel   | direction | handshake             | payload
//  s_axis    | in        | tvalid/tready         | tuser mode, tdata row/col/alive
//  m_axis    | out       | tvalid/tready         | tdata cell_alive/generations_run/stable
//  cfg       | in        | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// An in-range load or read item goes through ST_LOAD_WR or ST_READ_CAP, then ST_RESP; an
// out-of-range load or read, an unused mode or a zero-generation run goes straight to ST_RESP.
// Each generation of a run goes through ST_GEN_START, ST_GEN_MID, a ST_ROW_RD, ST_ROW_CAP and
// ST_ROW_CALC pass per row, and ST_GEN_END; the rule unit is paced by the bank read port.
// Reset clears the row valid bits of both banks at once; no clearing pass is needed.
// The block accepts one item at a time; a held result stalls only the next result.
// cfg_ready is always high.

module life_grid_generation_engine #(
  parameter int GRID_MAX = lgge_pkg::GRID_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [5:0] row, [11:6] col, [12] alive, [15:13] zero
  input  logic [lgge_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] mode
  input  logic [lgge_pkg::MODE_W-1:0]      s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] cell_alive, [16:1] generations_run, [17] stable, [23:18] zero
  output logic [lgge_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [lgge_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import lgge_pkg::*;

  localparam int RW = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
  localparam int NW = $clog2(GRID_MAX + 1);
  localparam int CW = (NW > SIZE_CFG_W) ? NW : SIZE_CFG_W;

  state_t state;
  state_t state_next;

  logic [SIZE_CFG_W-1:0] grid_size;
  logic [GENS_W-1:0]     max_gens;
  logic [GENS_W-1:0]     last_count;
  logic                  last_stable;
  logic                  cur_bank;

  logic                  out_valid;
  logic                  out_cell;
  logic [GENS_W-1:0]     out_gens;
  logic                  out_stable;

  logic [RW-1:0]         it_row;
  logic [RW-1:0]         it_col;
  logic                  it_alive;
  logic                  cell_q;
  logic [RW-1:0]         row_cnt;
  logic                  changed;
  logic [GENS_W-1:0]     gens_cnt;
  logic [GRID_MAX-1:0]   above;
  logic [GRID_MAX-1:0]   mid;
  logic [GRID_MAX-1:0]   below;
  logic [GRID_MAX-1:0]   dst_old;

  logic                  s_accept;
  logic                  m_accept;
  logic                  out_free;
  logic [NW-1:0]         size_n;
  logic [GRID_MAX-1:0]   col_mask;
  logic [CW-1:0]         row_ext;
  logic [CW-1:0]         col_ext;
  logic                  in_range_now;
  logic [MODE_W-1:0]     in_mode;
  logic [NW-1:0]         row_plus;
  logic                  below_ok;
  logic                  last_row;
  logic [GENS_W-1:0]     gens_plus;
  logic                  run_done;
  logic [GRID_MAX-1:0]   new_row;
  logic [GRID_MAX-1:0]   load_row;

  logic                  src_rd_en;
  logic [RW-1:0]         src_rd_addr;
  logic                  dst_rd_en;
  logic [RW-1:0]         dst_rd_addr;
  logic                  cur_wr_en;
  logic                  dst_wr_en;
  logic [RW-1:0]         wr_addr;
  logic [GRID_MAX-1:0]   wr_data;
  logic [GRID_MAX-1:0]   src_rd_data;
  logic [GRID_MAX-1:0]   dst_rd_data;

  logic                  b_rd_en   [2];
  logic [RW-1:0]         b_rd_addr [2];
  logic [GRID_MAX-1:0]   b_rd_data [2];
  logic                  b_wr_en   [2];

  // Handshakes and derived values.
  assign s_axis_tready = (state == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_accept      = m_axis_tvalid && m_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign cfg_ready     = 1'b1;
  assign in_mode       = s_axis_tuser;

  always_comb begin
    logic [CW-1:0] gs;
    gs = CW'(grid_size);
    if (gs == '0) begin
      size_n = NW'(1);
    end else if (gs > CW'(GRID_MAX)) begin
      size_n = NW'(GRID_MAX);
    end else begin
      size_n = gs[NW-1:0];
    end
  end

  always_comb begin
    for (int c = 0; c < GRID_MAX; c++) begin
      col_mask[c] = NW'(c) < size_n;
    end
  end

  assign row_ext      = CW'(s_axis_tdata[COORD_W-1:0]);
  assign col_ext      = CW'(s_axis_tdata[2*COORD_W-1:COORD_W]);
  assign in_range_now = (row_ext < CW'(size_n)) && (col_ext < CW'(size_n));
  assign row_plus     = NW'(row_cnt) + NW'(1);
  assign below_ok     = row_plus < size_n;
  assign last_row     = NW'(row_cnt) == (size_n - NW'(1));
  assign gens_plus    = gens_cnt + 16'd1;
  assign run_done     = !changed || (gens_plus == max_gens);

  assign src_rd_data = b_rd_data[cur_bank];
  assign dst_rd_data = b_rd_data[~cur_bank];

  always_comb begin
    load_row         = src_rd_data;
    load_row[it_col] = it_alive;
  end

  lgge_row_rule #(
    .COLS(GRID_MAX)
  ) u_row_rule (
    .above   (above),
    .mid     (mid),
    .below   (below),
    .next_row(new_row)
  );

  // The current bank serves loads, reads and the source rows; the other takes new rows.
  for (genvar k = 0; k < 2; k++) begin : g_bank
    logic is_src;
    assign is_src       = (cur_bank == 1'(k));
    assign b_rd_en[k]   = is_src ? src_rd_en : dst_rd_en;
    assign b_rd_addr[k] = is_src ? src_rd_addr : dst_rd_addr;
    assign b_wr_en[k]   = is_src ? cur_wr_en : dst_wr_en;

    lgge_bank #(
      .ROWS(GRID_MAX),
      .COLS(GRID_MAX)
    ) u_bank (
      .clk    (clk),
      .rst    (rst),
      .rd_en  (b_rd_en[k]),
      .rd_addr(b_rd_addr[k]),
      .rd_data(b_rd_data[k]),
      .wr_en  (b_wr_en[k]),
      .wr_addr(wr_addr),
      .wr_data(wr_data)
    );
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_accept) begin
          case (in_mode)
            MODE_LOAD: state_next = in_range_now ? ST_LOAD_WR : ST_RESP;
            MODE_READ: state_next = in_range_now ? ST_READ_CAP : ST_RESP;
            MODE_RUN:  state_next = (max_gens == '0) ? ST_RESP : ST_GEN_START;
            default:   state_next = ST_RESP;
          endcase
        end
      end
      ST_LOAD_WR:   state_next = ST_RESP;
      ST_READ_CAP:  state_next = ST_RESP;
      ST_GEN_START: state_next = ST_GEN_MID;
      ST_GEN_MID:   state_next = ST_ROW_RD;
      ST_ROW_RD:    state_next = ST_ROW_CAP;
      ST_ROW_CAP:   state_next = ST_ROW_CALC;
      ST_ROW_CALC:  state_next = last_row ? ST_GEN_END : ST_ROW_RD;
      ST_GEN_END:   state_next = run_done ? ST_RESP : ST_GEN_START;
      ST_RESP:      state_next = out_free ? ST_IDLE : ST_RESP;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Memory port controls.
  always_comb begin
    src_rd_en   = 1'b0;
    src_rd_addr = '0;
    dst_rd_en   = 1'b0;
    dst_rd_addr = '0;
    cur_wr_en   = 1'b0;
    dst_wr_en   = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;
    case (state)
      ST_IDLE: begin
        if (s_accept && in_range_now &&
            ((in_mode == MODE_LOAD) || (in_mode == MODE_READ))) begin
          src_rd_en   = 1'b1;
          src_rd_addr = row_ext[RW-1:0];
        end
      end
      ST_LOAD_WR: begin
        cur_wr_en = 1'b1;
        wr_addr   = it_row;
        wr_data   = load_row;
      end
      ST_GEN_START: begin
        src_rd_en = 1'b1;
      end
      ST_ROW_RD: begin
        src_rd_en   = below_ok;
        src_rd_addr = below_ok ? row_plus[RW-1:0] : '0;
        dst_rd_en   = 1'b1;
        dst_rd_addr = row_cnt;
      end
      ST_ROW_CALC: begin
        // Columns outside the grid in use keep what the target bank held.
        dst_wr_en = 1'b1;
        wr_addr   = row_cnt;
        wr_data   = (new_row & col_mask) | (dst_old & ~col_mask);
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      grid_size   <= GRID_SIZE_RESET;
      max_gens    <= MAX_GENS_RESET;
      last_count  <= '0;
      last_stable <= 1'b0;
      cur_bank    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_GRID_SIZE: grid_size <= cfg_data[SIZE_CFG_W-1:0];
          CFG_MAX_GENS:  max_gens  <= cfg_data[GENS_W-1:0];
          default: begin
          end
        endcase
      end
      if (state == ST_IDLE && s_accept && in_mode == MODE_RUN && max_gens == '0) begin
        last_count  <= '0;
        last_stable <= 1'b0;
      end
      if (state == ST_GEN_END) begin
        cur_bank <= ~cur_bank;
        if (run_done) begin
          last_count  <= gens_plus;
          last_stable <= !changed;
        end
      end
      if (state == ST_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (m_accept) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_accept) begin
          it_row   <= row_ext[RW-1:0];
          it_col   <= col_ext[RW-1:0];
          it_alive <= s_axis_tdata[2*COORD_W];
          cell_q   <= 1'b0;
          gens_cnt <= '0;
        end
      end
      ST_READ_CAP: begin
        cell_q <= src_rd_data[it_col];
      end
      ST_GEN_START: begin
        row_cnt <= '0;
        changed <= 1'b0;
        above   <= '0;
      end
      ST_GEN_MID: begin
        mid <= src_rd_data & col_mask;
      end
      ST_ROW_CAP: begin
        below   <= below_ok ? (src_rd_data & col_mask) : '0;
        dst_old <= dst_rd_data;
      end
      ST_ROW_CALC: begin
        changed <= changed || (|((new_row & col_mask) ^ mid));
        above   <= mid;
        mid     <= below;
        row_cnt <= row_cnt + RW'(1);
      end
      ST_GEN_END: begin
        gens_cnt <= gens_plus;
      end
      ST_RESP: begin
        if (out_free) begin
          out_cell   <= cell_q;
          out_gens   <= last_count;
          out_stable <= last_stable;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b000000, out_stable, out_gens, out_cell};

  // The row counter stays inside the grid in use.
  a_row_in_grid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROW_CALC) |-> (NW'(row_cnt) < size_n))
    else $error("row counter left the grid in use");

  // A run never computes more generations than allowed.
  a_gens_limit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GEN_END) |-> (gens_cnt < max_gens))
    else $error("generation count passed max_generations");

  // Only one bank is written in any cycle.
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(b_wr_en[0] && b_wr_en[1]))
    else $error("both banks written in one cycle");

  // A stable run has computed at least one generation.
  a_stable_count: assert property (@(posedge clk) disable iff (rst)
    last_stable |-> (last_count != '0))
    else $error("stable flag set with zero generations");

endmodule

// File: sv/lgge_bank.sv
// One grid bank: a row-organized memory with one read and one write port.
// Each row has a valid bit cleared at reset; a row never written reads as all dead.

module lgge_bank #(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [$clog2(ROWS)-1:0]  rd_addr,
  output logic [COLS-1:0]          rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(ROWS)-1:0]  wr_addr,
  input  logic [COLS-1:0]          wr_data
);

  logic [COLS-1:0] mem [ROWS];
  logic [ROWS-1:0] row_valid;
  logic [COLS-1:0] rd_q;
  logic            rd_valid_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_q <= row_valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

// File: sv/lgge_row_rule.sv
// Rule unit shared by every row of every generation: one lane per column.
// Depends on lgge_pkg for the rule; bits outside the grid arrive as zero.

module lgge_row_rule #(
  parameter int COLS = 64
) (
  input  logic [COLS-1:0] above,
  input  logic [COLS-1:0] mid,
  input  logic [COLS-1:0] below,
  output logic [COLS-1:0] next_row
);

  import lgge_pkg::*;

  logic [COLS+1:0] pa;
  logic [COLS+1:0] pm;
  logic [COLS+1:0] pb;

  // A dead cell on each side stands for the border.
  assign pa = {1'b0, above, 1'b0};
  assign pm = {1'b0, mid, 1'b0};
  assign pb = {1'b0, below, 1'b0};

  always_comb begin
    logic [COUNT_W-1:0] cnt;
    for (int c = 0; c < COLS; c++) begin
      cnt = {3'b000, pa[c]} + {3'b000, pa[c+1]} + {3'b000, pa[c+2]}
          + {3'b000, pm[c]} + {3'b000, pm[c+2]}
          + {3'b000, pb[c]} + {3'b000, pb[c+1]} + {3'b000, pb[c+2]};
      next_row[c] = life_rule(cnt, mid[c]);
    end
  end

endmodule
